// ===== hw/rtl/sorted_key_table_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_key_table_macros
// Assertion macros used by the sorted key table top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SKT_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SKT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Word types, request and status codes and controller states of the sorted
// key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_BITS  = 32;
  localparam int WORD_BITS = 32;
  localparam int SLOT_BITS = 9;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_NEW  = 2'd0;
  localparam logic [1:0] ST_HIT  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [KEY_BITS-1:0] key;
    logic [WORD_BITS-1:0]       payload;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [WORD_BITS-1:0] found_payload;
    logic [SLOT_BITS-1:0] slot;
    logic [SLOT_BITS-1:0] entry_count;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_SHIFT,
    S_INS,
    S_DONE
  } skt_state_t;

endpackage

// ===== hw/rtl/skt_ram.sv =====
// ----------------------------------------------------------------------------
// skt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer of the sorted key table: binary search over the entry RAM, entry
// shift for inserts, fill count and result assembly.
// ----------------------------------------------------------------------------
module skt_ctrl
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  in_word_t                             in_word,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output out_word_t                            res_word,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     fill,
  output logic                                 mem_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]       mem_waddr,
  output logic [KEY_BITS+PAYLOAD_BITS-1:0]     mem_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0]       mem_raddr,
  input  logic [KEY_BITS+PAYLOAD_BITS-1:0]     mem_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = PAYLOAD_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  skt_state_t state_r, state_nxt;
  logic [1:0]                 req_r, req_nxt;
  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [PW-1:0]              pay_r, pay_nxt;
  logic [CW-1:0]              lo_r, lo_nxt;
  logic [CW-1:0]              hi_r, hi_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  out_word_t                  res_r, res_nxt;

  logic [CW-1:0]              mid;
  logic [CW-1:0]              fill_inc;
  logic [CW-1:0]              fill_dec;
  logic signed [KEY_BITS-1:0] rd_key;
  logic [PW-1:0]              rd_pay;
  logic [63:0]                in_pay_ext;
  logic [63:0]                rd_pay_ext;
  logic [31:0]                lo_ext;
  logic [31:0]                mid_ext;
  logic [31:0]                fill_ext;
  logic [31:0]                fill_inc_ext;

  // search midpoint and count arithmetic
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign fill_inc = fill_r + 1'b1;
  assign fill_dec = fill_r - 1'b1;

  // entry fields from the RAM
  assign rd_key = $signed(mem_rdata[KEY_BITS+PW-1:PW]);
  assign rd_pay = mem_rdata[PW-1:0];

  // resizing to the fixed word fields
  assign in_pay_ext   = 64'(in_word.payload);
  assign rd_pay_ext   = 64'(rd_pay);
  assign lo_ext       = 32'(lo_r);
  assign mid_ext      = 32'(mid);
  assign fill_ext     = 32'(fill_r);
  assign fill_inc_ext = 32'(fill_inc);

  assign res_word = res_r;
  assign fill     = fill_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    key_r <= key_nxt;
    pay_r <= pay_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    ptr_r <= ptr_nxt;
    res_r <= res_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ptr_nxt   = ptr_r;
    fill_nxt  = fill_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = lo_r[AW-1:0];
    mem_wdata = {key_r, pay_r};
    mem_raddr = mid[AW-1:0];

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_word.req_type;
          key_nxt = in_word.key;
          pay_nxt = in_pay_ext[PW-1:0];
          lo_nxt  = '0;
          hi_nxt  = fill_r;
          case (in_word.req_type)
            REQ_INSERT, REQ_LOOKUP: begin
              state_nxt = S_SRCH;
            end
            REQ_CLEAR: begin
              fill_nxt              = '0;
              res_nxt.status        = ST_NEW;
              res_nxt.found_payload = '0;
              res_nxt.slot          = '0;
              res_nxt.entry_count   = '0;
              state_nxt             = S_DONE;
            end
            default: begin
              res_nxt.status        = ST_MISS;
              res_nxt.found_payload = '0;
              res_nxt.slot          = '0;
              res_nxt.entry_count   = fill_ext[SLOT_BITS-1:0];
              state_nxt             = S_DONE;
            end
          endcase
        end
      end

      // issue a probe read, or settle a miss, a full table, an append or the start of a shift
      S_SRCH: begin
        res_nxt.found_payload = '0;
        res_nxt.slot          = lo_ext[SLOT_BITS-1:0];
        res_nxt.entry_count   = fill_ext[SLOT_BITS-1:0];
        if (lo_r < hi_r) begin
          mem_raddr = mid[AW-1:0];
          state_nxt = S_CMP;
        end else if (req_r == REQ_LOOKUP) begin
          res_nxt.status = ST_MISS;
          state_nxt      = S_DONE;
        end else if (fill_r == DEPTH_C) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_DONE;
        end else if (lo_r == fill_r) begin
          // append at the end, nothing to move
          mem_we              = 1'b1;
          mem_waddr           = lo_r[AW-1:0];
          fill_nxt            = fill_inc;
          res_nxt.status      = ST_NEW;
          res_nxt.entry_count = fill_inc_ext[SLOT_BITS-1:0];
          state_nxt           = S_DONE;
        end else begin
          mem_raddr = fill_dec[AW-1:0];
          ptr_nxt   = fill_dec[AW-1:0];
          state_nxt = S_SHIFT;
        end
      end

      // compare probed key: on a hit report it (and replace it on an insert), else narrow the bounds
      S_CMP: begin
        if (rd_key == key_r) begin
          if (req_r == REQ_INSERT) begin
            mem_we    = 1'b1;
            mem_waddr = mid[AW-1:0];
          end
          res_nxt.status        = ST_HIT;
          res_nxt.found_payload = rd_pay_ext[WORD_BITS-1:0];
          res_nxt.slot          = mid_ext[SLOT_BITS-1:0];
          res_nxt.entry_count   = fill_ext[SLOT_BITS-1:0];
          state_nxt             = S_DONE;
        end else begin
          if (rd_key < key_r) begin
            lo_nxt = mid + 1'b1;
          end else begin
            hi_nxt = mid;
          end
          state_nxt = S_SRCH;
        end
      end

      // move one entry up per cycle, top down
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r + 1'b1;
        mem_wdata = mem_rdata;
        if (ptr_r == lo_r[AW-1:0]) begin
          state_nxt = S_INS;
        end else begin
          ptr_nxt   = ptr_r - 1'b1;
          mem_raddr = ptr_r - 1'b1;
        end
      end

      // drop the new entry into the gap
      S_INS: begin
        mem_we              = 1'b1;
        mem_waddr           = lo_r[AW-1:0];
        fill_nxt            = fill_inc;
        res_nxt.status      = ST_NEW;
        res_nxt.entry_count = fill_inc_ext[SLOT_BITS-1:0];
        state_nxt           = S_DONE;
      end

      // hand the result word to the output register
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sorted_key_table.sv =====
// Throughput: one word at a time, set by the probe loop and the one-entry shift.
// Reset: rst_n (synchronous) empties the table and the output register; the RAM
// is not cleared, so words are taken right after reset.
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of entries sorted by signed key with insert, lookup and clear.
// ----------------------------------------------------------------------------
`include "sorted_key_table_macros.svh"

module sorted_key_table
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_BITS + PAYLOAD_BITS;

  logic          res_valid;
  logic          res_ready;
  out_word_t     res_word;
  logic [CW-1:0] fill;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;
  logic          at_depth;
  logic          full_res;
  logic          clear_take;

  // sequencer
  skt_ctrl #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .fill      (fill),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // entry store: key over payload
  skt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // terms for the checks
  assign at_depth   = (fill == CW'(TABLE_DEPTH));
  assign full_res   = res_valid && (res_word.status == ST_FULL);
  assign clear_take = in_valid && in_ready && (in_word.req_type == REQ_CLEAR);

  // checks
  `SKT_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill <= CW'(TABLE_DEPTH), "fill above depth")
  `SKT_ASSERT_NOW(a_full_only_when_full, clk, rst_n, full_res, at_depth, "full with room left")
  `SKT_ASSERT_NEXT(a_clear_empties, clk, rst_n, clear_take, fill == '0, "clear left entries")
  `SKT_ASSERT_NOW(a_no_accept_while_busy, clk, rst_n, in_ready, !res_valid, "taken while busy")

endmodule

// ===== tb/sorted_key_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_test
// Drives insert, lookup, clear and undefined requests into the sorted key
// table with random gaps on the input side and random stalls on the result
// side. A tracker keeps its own copy of the sorted table, works out the
// result word of every accepted request and checks each returned word
// against the oldest one still due. A fill phase takes the table to full
// depth to reach refused inserts and replacements in a full table.
// ----------------------------------------------------------------------------
module sorted_key_table_test;
  import skt_pkg::*;

  localparam int TABLE_SIZE = 256;
  localparam logic [1:0] REQ_UNDEF = 2'd3;
  localparam logic signed [KEY_BITS-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_BITS-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam longint TIMEOUT_NS = 40_000_000;
  localparam int TAIL_CYCLES = 300;

  // idle patterns for both sides
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_FULL   = 1;
  localparam int IDLE_SPARSE = 2;

  // shadow copy of the table and the result words still due
  class key_table_tracker;
    logic signed [KEY_BITS-1:0] key_at[TABLE_SIZE];
    logic [WORD_BITS-1:0]       pay_at[TABLE_SIZE];
    int unsigned                fill;
    int unsigned                peak_fill;
    out_word_t                  due_results[$];
    int                         errors;
    int                         status_seen[4];

    // binary search over the held entries
    function automatic void find_slot(input logic signed [KEY_BITS-1:0] k,
                                      output bit hit, output int unsigned pos);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo  = 0;
      hi  = fill;
      hit = 1'b0;
      pos = 0;
      while (lo < hi && !hit) begin
        mid = lo + (hi - lo) / 2;
        if (key_at[mid] == k) begin
          hit = 1'b1;
          pos = mid;
        end else if (key_at[mid] < k) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      if (!hit) pos = lo;
    endfunction

    function automatic void note_request(input in_word_t w);
      out_word_t                  res;
      logic signed [KEY_BITS-1:0] k;
      bit                         hit;
      int unsigned                pos;
      res        = '0;
      res.status = ST_MISS;
      k          = w.key;
      pos        = 0;
      case (w.req_type)
        REQ_INSERT: begin
          find_slot(k, hit, pos);
          if (hit) begin
            res.found_payload = pay_at[pos];
            pay_at[pos]       = w.payload;
            res.status        = ST_HIT;
          end else if (fill >= TABLE_SIZE) begin
            res.status = ST_FULL;
          end else begin
            // open a gap at the insertion point
            for (int i = fill; i > int'(pos); i--) begin
              key_at[i] = key_at[i-1];
              pay_at[i] = pay_at[i-1];
            end
            key_at[pos] = k;
            pay_at[pos] = w.payload;
            fill++;
            res.status = ST_NEW;
          end
        end
        REQ_LOOKUP: begin
          find_slot(k, hit, pos);
          if (hit) begin
            res.found_payload = pay_at[pos];
            res.status        = ST_HIT;
          end
        end
        REQ_CLEAR: begin
          fill       = 0;
          res.status = ST_NEW;
        end
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      res.slot        = pos[SLOT_BITS-1:0];
      res.entry_count = fill[SLOT_BITS-1:0];
      due_results.push_back(res);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function automatic void check_result(input out_word_t got);
      out_word_t want;
      if (due_results.size() == 0) begin
        $error("result word with nothing due: %p", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      status_seen[got.status]++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("found_payload", want.found_payload, got.found_payload);
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  key_table_tracker tracker = new();
  int send_mode = IDLE_NONE;
  int sink_mode = IDLE_FULL;
  int sent      = 0;

  sorted_key_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait(input int mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 11);
      default:   return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    endcase
  endfunction

  // hand one request word to the block and note it once taken
  task automatic send_word(input in_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) send_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(w);
    sent++;
  endtask

  task automatic send_req(input logic [1:0] op, input logic signed [KEY_BITS-1:0] k,
                          input logic [WORD_BITS-1:0] pay);
    in_word_t w;
    w.req_type = op;
    w.key      = k;
    w.payload  = pay;
    send_word(w);
  endtask

  // hold off new words until every due result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_BITS-1:0] pick_key(input int span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel >= 6 && sel <= 7 && tracker.fill > 0)
      return tracker.key_at[$urandom_range(0, tracker.fill - 1)] + $urandom_range(0, 2) - 1;
    if (sel == 8) return $urandom;
    if (sel == 9) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return 0;
        default: return -1;
      endcase
    end
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // random mix of all request kinds, keys mostly from a range of the given span
  task automatic run_mix(input int count, input int span);
    int         r;
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 52)      op = REQ_INSERT;
      else if (r < 91) op = REQ_LOOKUP;
      else if (r < 94) op = REQ_CLEAR;
      else             op = REQ_UNDEF;
      send_req(op, pick_key(span), pick_payload());
    end
  endtask

  // take the table to full depth, then poke at it while full
  task automatic run_fill();
    logic signed [KEY_BITS-1:0] k;
    send_req(REQ_CLEAR, $urandom, $urandom);
    while (tracker.fill < TABLE_SIZE) send_req(REQ_INSERT, $urandom, pick_payload());
    send_req(REQ_INSERT, KEY_MIN, '1);
    send_req(REQ_INSERT, KEY_MAX, '0);
    for (int n = 0; n < 40; n++) begin
      k = tracker.key_at[$urandom_range(0, TABLE_SIZE - 1)];
      case ($urandom_range(0, 3))
        0:       send_req(REQ_INSERT, $urandom, pick_payload());
        1:       send_req(REQ_INSERT, k, pick_payload());
        2:       send_req(REQ_LOOKUP, k, $urandom);
        default: send_req(REQ_LOOKUP, $urandom, $urandom);
      endcase
    end
  endtask

  // result side: random stalls after each word taken
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_result(out_word);
        if ($urandom_range(0, 29) == 0) sink_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
        stall = draw_wait(sink_mode);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes of key and payload, replace, miss, clear, undefined request
    send_req(REQ_LOOKUP, 0, '1);
    send_req(REQ_UNDEF, KEY_MAX, '1);
    send_req(REQ_INSERT, 0, '0);
    send_req(REQ_INSERT, KEY_MAX, '1);
    send_req(REQ_INSERT, KEY_MIN, 32'hA5A5_A5A5);
    send_req(REQ_INSERT, -1, 32'h5A5A_5A5A);
    send_req(REQ_INSERT, 1, 32'h0000_0001);
    send_req(REQ_INSERT, 0, '1);
    send_req(REQ_LOOKUP, KEY_MIN, '0);
    send_req(REQ_LOOKUP, KEY_MAX, '0);
    send_req(REQ_LOOKUP, 0, '0);
    send_req(REQ_LOOKUP, 2, '0);
    send_req(REQ_LOOKUP, KEY_MIN + 1, '0);
    send_req(REQ_LOOKUP, -2, '0);
    send_req(REQ_INSERT, KEY_MAX, '0);
    send_req(REQ_UNDEF, 0, 32'h1234_5678);
    send_req(REQ_CLEAR, -1, '1);
    send_req(REQ_LOOKUP, 0, '0);
    send_req(REQ_CLEAR, 0, '0);
    send_req(REQ_INSERT, 12345, 32'h8000_0000);
    send_req(REQ_INSERT, KEY_MIN, 32'h7FFF_FFFF);
    send_req(REQ_INSERT, KEY_MAX, 32'hFFFF_0000);
    send_req(REQ_LOOKUP, KEY_MAX, '0);

    // random part
    run_mix(450, 40);
    drain_results();
    run_fill();
    run_mix(300, 1000);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d new or cleared, %0d hit, %0d miss, %0d refused",
             sent, tracker.status_seen[ST_NEW], tracker.status_seen[ST_HIT],
             tracker.status_seen[ST_MISS], tracker.status_seen[ST_FULL]);
    $display("table held up to %0d entries", tracker.peak_fill);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
